// ===== design/rtsq_pkg.sv =====
// Shared types and constants of the resistive touch sample qualifier.
`default_nettype none

package rtsq_pkg;

  // Fixed field and register widths.
  localparam int unsigned SAMPLE_FIELD_W = 12;
  localparam int unsigned GAIN_W         = 20;
  localparam int unsigned OFFSET_W       = 16;
  localparam int unsigned WINDOW_W       = 12;
  localparam int unsigned POS_W          = 16;
  localparam int unsigned CAL_FRAC_BITS  = 16;
  localparam int unsigned APB_ADDR_W     = 5;
  localparam int unsigned APB_DATA_W     = 32;

  // Input command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_PEN_UP = 1'b1;

  // Register reset values.
  localparam logic [GAIN_W-1:0]          GAIN_X_RESET   = 20'd4129;
  localparam logic signed [OFFSET_W-1:0] OFFSET_X_RESET = -16'sd12;
  localparam logic [GAIN_W-1:0]          GAIN_Y_RESET   = 20'd5865;
  localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RESET = -16'sd32;
  localparam logic [WINDOW_W-1:0]        WINDOW_RESET   = 12'd50;

  // Position reported when no touch is present.
  localparam logic [POS_W-1:0] POS_NONE = 16'hFFFF;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_GAIN_X   = 3'd0,
    REG_OFFSET_X = 3'd1,
    REG_GAIN_Y   = 3'd2,
    REG_OFFSET_Y = 3'd3,
    REG_WINDOW   = 3'd4
  } reg_idx_t;

  // Kind of work handed from the front end to the back end.
  typedef enum logic {
    OP_SCAN   = 1'b0,
    OP_PEN_UP = 1'b1
  } op_t;

  // Which of the four groups of a scan is being collected.
  typedef enum logic [1:0] {
    GRP_X_FIRST  = 2'd0,
    GRP_Y_FIRST  = 2'd1,
    GRP_X_SECOND = 2'd2,
    GRP_Y_SECOND = 2'd3
  } grp_t;

endpackage

`default_nettype wire

// ===== design/rtsq_front.sv =====
// Front end: accumulates samples, forms trimmed means and queues scan work.
`default_nettype none

module rtsq_front #(
  parameter int unsigned SAMPLES_PER_READ = 5,
  parameter int unsigned SAMPLE_BITS      = 12,
  parameter int unsigned QUEUE_DEPTH      = 4,
  localparam int unsigned LVL_W   = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned ENTRY_W = 2 + 4 * SAMPLE_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_command,
  input  wire logic [rtsq_pkg::SAMPLE_FIELD_W-1:0]  in_sample,
  input  wire logic                                 in_raw,
  input  wire logic [LVL_W-1:0]                     q_level,
  output logic                                      q_push,
  output logic [ENTRY_W-1:0]                        q_data
);

  localparam int unsigned IN_BITS  = (SAMPLE_BITS < rtsq_pkg::SAMPLE_FIELD_W) ?
                                     SAMPLE_BITS : rtsq_pkg::SAMPLE_FIELD_W;
  localparam int unsigned CNT_W    = $clog2(SAMPLES_PER_READ);
  localparam int unsigned SUM_W    = SAMPLE_BITS + $clog2(SAMPLES_PER_READ);
  localparam int unsigned TRIM_DIV = SAMPLES_PER_READ - 2;
  localparam int unsigned SHIFT    = SUM_W + $clog2(TRIM_DIV);
  localparam int unsigned MUL_W    = SHIFT + 1;
  localparam int unsigned PROD_W   = SUM_W + MUL_W;
  // Reciprocal of the divisor, rounded up; exact for every trimmed sum.
  localparam longint unsigned MUL_L = ((64'd1 << SHIFT) + TRIM_DIV - 1) / TRIM_DIV;
  localparam logic [MUL_W-1:0] MUL  = MUL_W'(MUL_L);

  logic                      accept;
  logic [SAMPLE_BITS-1:0]    sample_v;
  logic [CNT_W-1:0]          in_cnt;
  rtsq_pkg::grp_t            grp;
  logic [SUM_W-1:0]          sum;
  logic [SAMPLE_BITS-1:0]    gmin;
  logic [SAMPLE_BITS-1:0]    gmax;
  logic [SUM_W-1:0]          acc_sum;
  logic [SAMPLE_BITS-1:0]    acc_min;
  logic [SAMPLE_BITS-1:0]    acc_max;
  logic                      last_in_group;

  logic                      ev_valid;
  rtsq_pkg::op_t             ev_op;
  rtsq_pkg::grp_t            ev_grp;
  logic [SUM_W-1:0]          ev_trim;
  logic                      ev_raw;
  logic [PROD_W-1:0]         mean_prod;
  logic [SAMPLE_BITS-1:0]    mean;
  logic [SAMPLE_BITS-1:0]    first_x;
  logic [SAMPLE_BITS-1:0]    first_y;
  logic [SAMPLE_BITS-1:0]    second_x;

  // Room is reserved for an entry held in the event register, which the queue level does not yet count.
  assign in_ready = ({1'b0, q_level} + {{LVL_W{1'b0}}, ev_valid}) <
                    (LVL_W + 1)'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;
  assign sample_v = SAMPLE_BITS'(in_sample[IN_BITS-1:0]);

  always_comb begin
    acc_sum       = sum + SUM_W'(sample_v);
    acc_min       = (sample_v < gmin) ? sample_v : gmin;
    acc_max       = (sample_v > gmax) ? sample_v : gmax;
    last_in_group = (in_cnt == CNT_W'(SAMPLES_PER_READ - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt   <= '0;
      grp      <= rtsq_pkg::GRP_X_FIRST;
      sum      <= '0;
      gmin     <= '1;
      gmax     <= '0;
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= 1'b0;
      if (accept) begin
        if (in_command == rtsq_pkg::CMD_PEN_UP) begin
          in_cnt   <= '0;
          grp      <= rtsq_pkg::GRP_X_FIRST;
          sum      <= '0;
          gmin     <= '1;
          gmax     <= '0;
          ev_valid <= 1'b1;
        end else if (last_in_group) begin
          in_cnt   <= '0;
          grp      <= rtsq_pkg::grp_t'(grp + 2'd1);
          sum      <= '0;
          gmin     <= '1;
          gmax     <= '0;
          ev_valid <= 1'b1;
        end else begin
          in_cnt <= in_cnt + 1'b1;
          sum    <= acc_sum;
          gmin   <= acc_min;
          gmax   <= acc_max;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_op   <= (in_command == rtsq_pkg::CMD_PEN_UP) ? rtsq_pkg::OP_PEN_UP :
                                                         rtsq_pkg::OP_SCAN;
      ev_grp  <= grp;
      ev_trim <= acc_sum - SUM_W'(acc_min) - SUM_W'(acc_max);
      ev_raw  <= in_raw;
    end
  end

  // Trimmed sum divided by the kept sample count through the reciprocal.
  assign mean_prod = PROD_W'(ev_trim) * PROD_W'(MUL);
  assign mean      = mean_prod[SHIFT +: SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (ev_valid && (ev_op == rtsq_pkg::OP_SCAN)) begin
      unique case (ev_grp)
        rtsq_pkg::GRP_X_FIRST:  first_x  <= mean;
        rtsq_pkg::GRP_Y_FIRST:  first_y  <= mean;
        rtsq_pkg::GRP_X_SECOND: second_x <= mean;
        rtsq_pkg::GRP_Y_SECOND: ;
      endcase
    end
  end

  assign q_push = ev_valid && ((ev_op == rtsq_pkg::OP_PEN_UP) ||
                               (ev_grp == rtsq_pkg::GRP_Y_SECOND));
  assign q_data = {ev_op, ev_raw, first_x, second_x, first_y, mean};

endmodule

`default_nettype wire

// ===== design/rtsq_fifo.sv =====
// Short queue between the front end and the back end.
`default_nettype none

module rtsq_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 50,
  localparam int unsigned LVL_W = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [WIDTH-1:0]  push_data,
  input  wire logic              pop,
  output logic                   rd_valid,
  output logic [WIDTH-1:0]       rd_data,
  output logic [LVL_W-1:0]       level
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  assign rd_valid = (level != '0);
  assign rd_data  = mem[rd_ptr];

`ifndef SYNTHESIS
  // The front end's credit check must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ((level != LVL_W'(DEPTH)) || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (level != '0))
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== design/rtsq_back.sv =====
// Back end: agreement check, averaging, calibration and press tracking.
`default_nettype none

module rtsq_back #(
  parameter int unsigned SAMPLE_BITS = 12,
  localparam int unsigned ENTRY_W = 2 + 4 * SAMPLE_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  q_valid,
  input  wire logic [ENTRY_W-1:0]                    q_data,
  output logic                                       q_pop,
  input  wire logic [rtsq_pkg::GAIN_W-1:0]           gain_x,
  input  wire logic signed [rtsq_pkg::OFFSET_W-1:0]  offset_x,
  input  wire logic [rtsq_pkg::GAIN_W-1:0]           gain_y,
  input  wire logic signed [rtsq_pkg::OFFSET_W-1:0]  offset_y,
  input  wire logic [rtsq_pkg::WINDOW_W-1:0]         agree_window,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       pressed,
  output logic                                       caught,
  output logic [rtsq_pkg::POS_W-1:0]                 pos_x,
  output logic [rtsq_pkg::POS_W-1:0]                 pos_y,
  output logic [rtsq_pkg::POS_W-1:0]                 press_x,
  output logic [rtsq_pkg::POS_W-1:0]                 press_y,
  output logic                                       reads_agreed
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned CMP_W  = (SB > rtsq_pkg::WINDOW_W) ? SB : rtsq_pkg::WINDOW_W;
  localparam int unsigned PROD_W = rtsq_pkg::GAIN_W + SB;
  localparam int unsigned POS_W  = rtsq_pkg::POS_W;

  rtsq_pkg::op_t   q_op;
  logic            q_raw;
  logic [SB-1:0]   fx, sx, fy, sy;
  logic [SB-1:0]   d_x, d_y;
  logic [SB:0]     sum_x, sum_y;
  logic [SB-1:0]   ax, ay;
  logic            agree_now;

  logic            adv;
  logic            s1_ready;
  logic            s1_valid;
  rtsq_pkg::op_t   s1_op;
  logic            s1_agreed;
  logic            s1_raw;
  logic [SB-1:0]   s1_ax, s1_ay;
  logic [PROD_W-1:0] s1_prod_x, s1_prod_y;

  logic [POS_W-1:0] cal_x, cal_y;
  logic [POS_W-1:0] new_x, new_y;
  logic [POS_W-1:0] cur_x_next, cur_y_next;

  logic             down_flag;
  logic             catch_flag;
  logic [POS_W-1:0] current_x, current_y;
  logic [POS_W-1:0] start_x, start_y;
  logic             agreed;

  // Unpack the queued scan.
  assign q_op  = rtsq_pkg::op_t'(q_data[ENTRY_W-1]);
  assign q_raw = q_data[ENTRY_W-2];
  assign fx    = q_data[3*SB +: SB];
  assign sx    = q_data[2*SB +: SB];
  assign fy    = q_data[SB +: SB];
  assign sy    = q_data[0 +: SB];

  always_comb begin
    d_x       = (fx > sx) ? fx - sx : sx - fx;
    d_y       = (fy > sy) ? fy - sy : sy - fy;
    agree_now = (CMP_W'(d_x) < CMP_W'(agree_window)) &&
                (CMP_W'(d_y) < CMP_W'(agree_window));
    sum_x     = {1'b0, fx} + {1'b0, sx};
    sum_y     = {1'b0, fy} + {1'b0, sy};
    ax        = sum_x[SB:1];
    ay        = sum_y[SB:1];
  end

  assign adv      = !out_valid || out_ready;
  assign s1_ready = !s1_valid || adv;
  assign q_pop    = q_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_op     <= q_op;
      s1_agreed <= agree_now;
      s1_raw    <= q_raw;
      s1_ax     <= ax;
      s1_ay     <= ay;
      s1_prod_x <= PROD_W'(gain_x) * PROD_W'(ax);
      s1_prod_y <= PROD_W'(gain_y) * PROD_W'(ay);
    end
  end

  always_comb begin
    cal_x = POS_W'(s1_prod_x >> rtsq_pkg::CAL_FRAC_BITS) + $unsigned(offset_x);
    cal_y = POS_W'(s1_prod_y >> rtsq_pkg::CAL_FRAC_BITS) + $unsigned(offset_y);
    new_x = s1_raw ? POS_W'(s1_ax) : cal_x;
    new_y = s1_raw ? POS_W'(s1_ay) : cal_y;
    cur_x_next = s1_agreed ? new_x : current_x;
    cur_y_next = s1_agreed ? new_y : current_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      down_flag  <= 1'b0;
      catch_flag <= 1'b0;
      current_x  <= '0;
      current_y  <= '0;
      start_x    <= '0;
      start_y    <= '0;
      agreed     <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= q_valid;
      end
      if (adv) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          if (s1_op == rtsq_pkg::OP_SCAN) begin
            agreed    <= s1_agreed;
            current_x <= cur_x_next;
            current_y <= cur_y_next;
            if (!down_flag) begin
              down_flag  <= 1'b1;
              catch_flag <= 1'b1;
              start_x    <= cur_x_next;
              start_y    <= cur_y_next;
            end
          end else begin
            agreed <= 1'b0;
            if (down_flag) begin
              down_flag <= 1'b0;
            end else begin
              start_x   <= '0;
              start_y   <= '0;
              current_x <= rtsq_pkg::POS_NONE;
              current_y <= rtsq_pkg::POS_NONE;
            end
          end
        end
      end
    end
  end

  // The result register is the tracked state itself.
  assign pressed      = down_flag;
  assign caught       = catch_flag;
  assign pos_x        = current_x;
  assign pos_y        = current_y;
  assign press_x      = start_x;
  assign press_y      = start_y;
  assign reads_agreed = agreed;

`ifndef SYNTHESIS
  a_pressed_caught: assert property (@(posedge clk) disable iff (rst)
    down_flag |-> catch_flag)
    else $error("pen held down without the caught flag");

  a_caught_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(catch_flag))
    else $error("caught flag cleared outside reset");
`endif

endmodule

`default_nettype wire

// ===== design/resistive_touch_sample_qualifier_top.sv =====
// Top level of the resistive touch sample qualifier with its register file.
`default_nettype none

// The block qualifies resistive touch-panel conversions. While the pen is down
// it receives scans of four groups of SAMPLES_PER_READ samples, in the order
// X, Y, X, Y. Each group is reduced to a trimmed mean (sum less minimum and
// maximum, divided by the remaining count). When the two X means and the two
// Y means each differ by less than the agreement window, their averages become
// the new position, either raw or scaled by the unsigned Q4.16 gain plus the
// signed offset and wrapped to 16 bits; otherwise the previous position stays.
// One result item leaves for every completed scan and for every pen-up item;
// other samples produce nothing. A pen-up item discards a partly collected
// scan. The input side takes one item every clock cycle while the queue has
// room; the front end keeps a running sum, minimum and maximum. A four-entry
// queue decouples it from the back end, which retires one scan per cycle
// unless the output stalls, through a two-stage pipeline (multiply, then
// offset and state update). Results pass through the event register, queue,
// multiply stage and state registers; a stalled output back-pressures the
// input only once the queue has filled. Configuration registers, 32 bits each
// on the APB port at byte addresses 0x00 gain_x, 0x04 offset_x, 0x08 gain_y,
// 0x0C offset_y and 0x10 agree_window, should be written only while idle.
module resistive_touch_sample_qualifier_top #(
  parameter int unsigned SAMPLES_PER_READ = 5,
  parameter int unsigned SAMPLE_BITS      = 12,
  parameter int unsigned QUEUE_DEPTH      = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input stream.
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [15:0]                         s_tdata,  // [11:0] sample
  input  wire logic [1:0]                          s_tuser,  // [0] command, [1] raw_mode
  // Result stream.
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [0] pressed, [1] caught, [17:2] pos_x, [33:18] pos_y, [49:34] press_x,
  // [65:50] press_y, [66] reads_agreed
  output logic [71:0]                              m_tdata,
  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rtsq_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [rtsq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rtsq_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready
);

  localparam int unsigned LVL_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_W = 2 + 4 * SAMPLE_BITS;
  localparam int unsigned DW      = rtsq_pkg::APB_DATA_W;

  // Configuration registers.
  logic [rtsq_pkg::GAIN_W-1:0]          gain_x;
  logic signed [rtsq_pkg::OFFSET_W-1:0] offset_x;
  logic [rtsq_pkg::GAIN_W-1:0]          gain_y;
  logic signed [rtsq_pkg::OFFSET_W-1:0] offset_y;
  logic [rtsq_pkg::WINDOW_W-1:0]        agree_window;
  rtsq_pkg::reg_idx_t                   reg_idx;
  logic                                 cfg_write;

  // Front-to-back queue.
  logic               q_push;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_pop;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_rd_data;
  logic [LVL_W-1:0]   q_level;

  // Result fields.
  logic                        pressed;
  logic                        caught;
  logic [rtsq_pkg::POS_W-1:0]  pos_x;
  logic [rtsq_pkg::POS_W-1:0]  pos_y;
  logic [rtsq_pkg::POS_W-1:0]  press_x;
  logic [rtsq_pkg::POS_W-1:0]  press_y;
  logic                        reads_agreed;

  assign pready    = 1'b1;
  assign reg_idx   = rtsq_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x       <= rtsq_pkg::GAIN_X_RESET;
      offset_x     <= rtsq_pkg::OFFSET_X_RESET;
      gain_y       <= rtsq_pkg::GAIN_Y_RESET;
      offset_y     <= rtsq_pkg::OFFSET_Y_RESET;
      agree_window <= rtsq_pkg::WINDOW_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        rtsq_pkg::REG_GAIN_X:   gain_x       <= pwdata[rtsq_pkg::GAIN_W-1:0];
        rtsq_pkg::REG_OFFSET_X: offset_x     <= $signed(pwdata[rtsq_pkg::OFFSET_W-1:0]);
        rtsq_pkg::REG_GAIN_Y:   gain_y       <= pwdata[rtsq_pkg::GAIN_W-1:0];
        rtsq_pkg::REG_OFFSET_Y: offset_y     <= $signed(pwdata[rtsq_pkg::OFFSET_W-1:0]);
        rtsq_pkg::REG_WINDOW:   agree_window <= pwdata[rtsq_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back; offsets are returned sign-extended.
  always_comb begin
    unique case (reg_idx)
      rtsq_pkg::REG_GAIN_X:   prdata = DW'(gain_x);
      rtsq_pkg::REG_OFFSET_X: prdata = DW'(unsigned'(DW'(offset_x)));
      rtsq_pkg::REG_GAIN_Y:   prdata = DW'(gain_y);
      rtsq_pkg::REG_OFFSET_Y: prdata = DW'(unsigned'(DW'(offset_y)));
      rtsq_pkg::REG_WINDOW:   prdata = DW'(agree_window);
      default:                prdata = '0;
    endcase
  end

  // Front end: sample accumulation and trimmed means.
  rtsq_front #(
    .SAMPLES_PER_READ (SAMPLES_PER_READ),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .QUEUE_DEPTH      (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_command (s_tuser[0]),
    .in_sample  (s_tdata[rtsq_pkg::SAMPLE_FIELD_W-1:0]),
    .in_raw     (s_tuser[1]),
    .q_level    (q_level),
    .q_push     (q_push),
    .q_data     (q_push_data)
  );

  rtsq_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .rd_valid  (q_valid),
    .rd_data   (q_rd_data),
    .level     (q_level)
  );

  // Back end: agreement, calibration and the press state.
  rtsq_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_rd_data),
    .q_pop        (q_pop),
    .gain_x       (gain_x),
    .offset_x     (offset_x),
    .gain_y       (gain_y),
    .offset_y     (offset_y),
    .agree_window (agree_window),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .pressed      (pressed),
    .caught       (caught),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .press_x      (press_x),
    .press_y      (press_y),
    .reads_agreed (reads_agreed)
  );

  assign m_tdata = {5'b0, reads_agreed, press_y, press_x, pos_y, pos_x, caught, pressed};

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the resistive touch sample qualifier top level.
`timescale 1ns / 100ps

// The testbench drives conversion and pen-up items into the input stream and
// checks every result item against its own model of the qualifier. The model
// lives in a small class that keeps a copy of the registers and of the scan
// state. The stimulus starts with a handful of directed items that cover the
// sample extremes and the pen-up cases. It then runs several phases of random
// scans, each with its own register setting and its own pattern of idle
// cycles on the two streams. Registers are only written once the block has
// gone quiet.
module testbench;

  localparam int unsigned SPR          = 5;     // samples per read (block default)
  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned DRAIN_CYCLES = 12;    // margin after the last expected result
  localparam int unsigned HOLD_CYCLES  = 200;   // long output hold-off
  localparam int unsigned QUIET_LIMIT  = 5000;  // cycles with no item moving
  localparam int unsigned PHASE_ITEMS  = 255;

  // One result item, last field in the lowest bits.
  typedef struct packed {
    bit        agreed;
    bit [15:0] press_y;
    bit [15:0] press_x;
    bit [15:0] pos_y;
    bit [15:0] pos_x;
    bit        caught;
    bit        pressed;
  } touch_report_t;

  // Tracks the qualifier state and holds the results it is expected to emit.
  class touch_tracker;
    bit [rtsq_pkg::GAIN_W-1:0]          gain_x, gain_y;
    bit signed [rtsq_pkg::OFFSET_W-1:0] off_x, off_y;
    bit [rtsq_pkg::WINDOW_W-1:0]        window;
    int unsigned                        conv_count;
    int unsigned                        acc_sum, acc_min, acc_max;
    int unsigned                        x_first, y_first, x_second;
    bit [rtsq_pkg::POS_W-1:0]           cur_x, cur_y, start_x, start_y;
    bit                                 pen_down, pen_caught;
    touch_report_t                      pending_reports[$];
    int unsigned                        mismatches;

    function new();
      gain_x     = rtsq_pkg::GAIN_X_RESET;
      off_x      = rtsq_pkg::OFFSET_X_RESET;
      gain_y     = rtsq_pkg::GAIN_Y_RESET;
      off_y      = rtsq_pkg::OFFSET_Y_RESET;
      window     = rtsq_pkg::WINDOW_RESET;
      conv_count = 0;
      clear_group();
      x_first    = 0;
      y_first    = 0;
      x_second   = 0;
      cur_x      = '0;
      cur_y      = '0;
      start_x    = '0;
      start_y    = '0;
      pen_down   = 1'b0;
      pen_caught = 1'b0;
      mismatches = 0;
    endfunction

    function void clear_group();
      acc_sum = 0;
      acc_min = (1 << rtsq_pkg::SAMPLE_FIELD_W) - 1;
      acc_max = 0;
    endfunction

    function void set_reg(rtsq_pkg::reg_idx_t idx, logic [31:0] val);
      unique case (idx)
        rtsq_pkg::REG_GAIN_X:   gain_x = val[rtsq_pkg::GAIN_W-1:0];
        rtsq_pkg::REG_OFFSET_X: off_x  = val[rtsq_pkg::OFFSET_W-1:0];
        rtsq_pkg::REG_GAIN_Y:   gain_y = val[rtsq_pkg::GAIN_W-1:0];
        rtsq_pkg::REG_OFFSET_Y: off_y  = val[rtsq_pkg::OFFSET_W-1:0];
        rtsq_pkg::REG_WINDOW:   window = val[rtsq_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    endfunction

    function bit close_enough(int unsigned a, int unsigned b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d < window;
    endfunction

    // Q4.16 gain, then the signed offset, wrapped to 16 bits.
    function bit [rtsq_pkg::POS_W-1:0] scale(int unsigned avg,
                                             bit [rtsq_pkg::GAIN_W-1:0] g,
                                             bit signed [rtsq_pkg::OFFSET_W-1:0] off);
      longint unsigned prod;
      prod = g;
      prod = (prod * avg) >> rtsq_pkg::CAL_FRAC_BITS;
      return prod[rtsq_pkg::POS_W-1:0] + off;
    endfunction

    function void take_sample(bit cmd, bit [rtsq_pkg::SAMPLE_FIELD_W-1:0] conv, bit raw);
      touch_report_t r;
      bit            agreed;
      int unsigned   mean;
      int unsigned   ax, ay;
      agreed = 1'b0;
      if (cmd == rtsq_pkg::CMD_SAMPLE) begin
        acc_sum += conv;
        if (conv < acc_min) acc_min = conv;
        if (conv > acc_max) acc_max = conv;
        if (conv_count % SPR != SPR - 1) begin
          conv_count++;
          return;
        end
        mean = (acc_sum - acc_min - acc_max) / (SPR - 2);
        clear_group();
        case (rtsq_pkg::grp_t'(conv_count / SPR))
          rtsq_pkg::GRP_X_FIRST: begin
            x_first = mean;
            conv_count++;
            return;
          end
          rtsq_pkg::GRP_Y_FIRST: begin
            y_first = mean;
            conv_count++;
            return;
          end
          rtsq_pkg::GRP_X_SECOND: begin
            x_second = mean;
            conv_count++;
            return;
          end
          default: ;
        endcase
        conv_count = 0;
        agreed = close_enough(x_first, x_second) && close_enough(y_first, mean);
        if (agreed) begin
          ax = (x_first + x_second) >> 1;
          ay = (y_first + mean) >> 1;
          if (raw) begin
            cur_x = ax[rtsq_pkg::POS_W-1:0];
            cur_y = ay[rtsq_pkg::POS_W-1:0];
          end else begin
            cur_x = scale(ax, gain_x, off_x);
            cur_y = scale(ay, gain_y, off_y);
          end
        end
        // A completed scan while the pen was up marks the start of a press.
        if (!pen_down) begin
          pen_down   = 1'b1;
          pen_caught = 1'b1;
          start_x    = cur_x;
          start_y    = cur_y;
        end
      end else begin
        conv_count = 0;
        clear_group();
        if (pen_down) begin
          pen_down = 1'b0;
        end else begin
          start_x = '0;
          start_y = '0;
          cur_x   = rtsq_pkg::POS_NONE;
          cur_y   = rtsq_pkg::POS_NONE;
        end
      end
      r.pressed = pen_down;
      r.caught  = pen_caught;
      r.pos_x   = cur_x;
      r.pos_y   = cur_y;
      r.press_x = start_x;
      r.press_y = start_y;
      r.agreed  = agreed;
      pending_reports.push_back(r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task match_report(logic [71:0] d);
      touch_report_t want;
      if (pending_reports.size() == 0) begin
        report_mismatch("result item arrived with nothing expected");
        return;
      end
      want = pending_reports.pop_front();
      if (d[0] !== want.pressed)
        report_mismatch($sformatf("pressed %b, expected %b", d[0], want.pressed));
      if (d[1] !== want.caught)
        report_mismatch($sformatf("caught %b, expected %b", d[1], want.caught));
      if (d[17:2] !== want.pos_x)
        report_mismatch($sformatf("pos_x %h, expected %h", d[17:2], want.pos_x));
      if (d[33:18] !== want.pos_y)
        report_mismatch($sformatf("pos_y %h, expected %h", d[33:18], want.pos_y));
      if (d[49:34] !== want.press_x)
        report_mismatch($sformatf("press_x %h, expected %h", d[49:34], want.press_x));
      if (d[65:50] !== want.press_y)
        report_mismatch($sformatf("press_y %h, expected %h", d[65:50], want.press_y));
      if (d[66] !== want.agreed)
        report_mismatch($sformatf("reads_agreed %b, expected %b", d[66], want.agreed));
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [15:0]                     s_tdata = '0;   // [11:0] sample
  logic [1:0]                      s_tuser = '0;   // [0] command, [1] raw_mode
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  // [0] pressed, [1] caught, [17:2] pos_x, [33:18] pos_y, [49:34] press_x,
  // [65:50] press_y, [66] reads_agreed
  logic [71:0]                     m_tdata;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [rtsq_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [rtsq_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [rtsq_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  touch_tracker tracker;
  int unsigned  items_sent = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  shift_hint = 40;
  int unsigned  holds_asked = 0;   // bumped by the stimulus to ask for a hold-off
  int unsigned  holds_done = 0;
  int unsigned  hold_left = 0;
  int unsigned  quiet_cycles = 0;

  resistive_touch_sample_qualifier_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_HALF) clk = ~clk;

  // The receiver stalls at random, and on request holds off for a long
  // stretch so that the internal queue fills and the input side stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_done) begin
      m_tready   <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every result item taken from the block is checked at the edge that
  // accepts it, using the values sampled before that edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_report(m_tdata);
  end

  // The run is abandoned if nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Offers one item, with random idle cycles ahead of it, and waits until the
  // block takes it. The valid is left high so that items can follow back to
  // back.
  task automatic send_item(input bit cmd, input bit [rtsq_pkg::SAMPLE_FIELD_W-1:0] conv,
                           input bit raw);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, conv};
    s_tuser  <= {raw, cmd};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    tracker.take_sample(cmd, conv, raw);
  endtask

  task automatic send_pen_up();
    send_item(rtsq_pkg::CMD_PEN_UP, $urandom_range(4095), $urandom_range(1));
  endtask

  // Stops offering items and waits until every expected result has come out,
  // then gives the back end time to finish anything still in flight.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the idle cycle after it keeps the next
  // transfer's psel from being driven twice in one step.
  task automatic reg_write(input rtsq_pkg::reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_settings(input int unsigned gx, input int ox, input int unsigned gy,
                                input int oy, input int unsigned win);
    reg_write(rtsq_pkg::REG_GAIN_X, gx);
    reg_write(rtsq_pkg::REG_OFFSET_X, ox);
    reg_write(rtsq_pkg::REG_GAIN_Y, gy);
    reg_write(rtsq_pkg::REG_OFFSET_Y, oy);
    reg_write(rtsq_pkg::REG_WINDOW, win);
    // Second reads are shifted by up to twice this, so that both agreeing
    // and disagreeing scans turn up under narrow windows.
    if (win == 0) shift_hint = 20;
    else if (win > 100) shift_hint = 100;
    else shift_hint = win;
  endtask

  function automatic bit [rtsq_pkg::SAMPLE_FIELD_W-1:0] clamp_conv(input int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'hFFF;
    return v[rtsq_pkg::SAMPLE_FIELD_W-1:0];
  endfunction

  // One group of conversions scattered around a centre, with the odd wild
  // sample that the trimmed mean should throw away.
  task automatic send_group(input int unsigned centre, input int unsigned spread);
    int v;
    for (int i = 0; i < SPR; i++) begin
      v = int'(centre) + int'($urandom_range(2 * spread)) - int'(spread);
      if ($urandom_range(15) == 0) v = $urandom_range(4095);
      send_item(rtsq_pkg::CMD_SAMPLE, clamp_conv(v), $urandom_range(1));
    end
  endtask

  // A complete X, Y, X, Y scan with random positions and random disagreement.
  task automatic send_scan();
    int unsigned cx, cy, spread;
    int          dx, dy;
    cx     = $urandom_range(4095);
    cy     = $urandom_range(4095);
    spread = ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
    dx     = $urandom_range(2 * shift_hint);
    dy     = ($urandom_range(1) == 0) ? 0 : $urandom_range(2 * shift_hint);
    if ($urandom_range(1) != 0) dx = -dx;
    if ($urandom_range(1) != 0) dy = -dy;
    send_group(cx, spread);
    send_group(cy, spread);
    send_group(clamp_conv(int'(cx) + dx), spread);
    send_group(clamp_conv(int'(cy) + dy), spread);
  endtask

  // Mostly well-formed scans, some broken off by a pen-up, and some runs of
  // fully random items; the latter always end in a pen-up so that the next
  // scan starts on a group boundary.
  task automatic run_random(input int unsigned target);
    int unsigned choice, n;
    while (items_sent < target) begin
      choice = $urandom_range(99);
      if (choice < 78) begin
        send_scan();
        if ($urandom_range(99) < 35) send_pen_up();
        if ($urandom_range(99) < 10) send_pen_up();
      end else if (choice < 90) begin
        n = $urandom_range(19, 1);
        repeat (n) send_item(rtsq_pkg::CMD_SAMPLE, $urandom_range(4095), $urandom_range(1));
        send_pen_up();
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) send_item($urandom_range(1), $urandom_range(4095), $urandom_range(1));
        send_pen_up();
      end
    end
  endtask

  // Directed opening: a pen-up with no press, a scan using both sample
  // extremes as outliers, release, a further pen-up that clears the
  // position, and a scan broken off after a few samples.
  task automatic run_directed();
    int unsigned scan_values[20] = '{4095, 0, 100, 100, 100,
                                     0, 4095, 2000, 2000, 2003,
                                     100, 101, 99, 4095, 0,
                                     2000, 1999, 2001, 0, 4095};
    send_pen_up();
    // The raw flag only counts on the last sample, so it is set on all but it.
    for (int i = 0; i < 20; i++) send_item(rtsq_pkg::CMD_SAMPLE, scan_values[i], i != 19);
    send_pen_up();
    send_pen_up();
    send_item(rtsq_pkg::CMD_SAMPLE, 12'hFFF, 1'b1);
    send_item(rtsq_pkg::CMD_SAMPLE, 12'h000, 1'b0);
    send_item(rtsq_pkg::CMD_SAMPLE, 12'hA5A, 1'b1);
    send_pen_up();
  endtask

  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    for (int phase = 0; phase < 5; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          // Reset settings, no idling, and one long output hold-off while
          // items keep coming.
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          holds_asked   <= holds_asked + 1;
        end
        1: begin
          // Largest gains and offsets, widest window: calibration wraps.
          apply_settings(20'hFFFFF, 32767, 20'hFFFFF, -32768, 4095);
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          // Zero gains and the narrowest usable window.
          apply_settings(0, -32768, 0, 32767, 1);
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        3: begin
          // Unity gain, and a zero window under which no reads agree.
          apply_settings(20'h10000, 0, 20'h10000, 0, 0);
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
        default: begin
          apply_settings($urandom_range(20'hFFFFF), int'($urandom_range(65535)) - 32768,
                         $urandom_range(20'hFFFFF), int'($urandom_range(65535)) - 32768,
                         $urandom_range(120, 1));
          send_idle_pct  = 10;
          recv_stall_pct = 10;
        end
      endcase
      run_random(items_sent + PHASE_ITEMS);
    end

    wait_drained();
    if (tracker.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== resistive_touch_sample_qualifier_top.f =====
design/rtsq_pkg.sv
design/rtsq_front.sv
design/rtsq_fifo.sv
design/rtsq_back.sv
design/resistive_touch_sample_qualifier_top.sv
sim/testbench.sv
